@@ design/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// shared constants, codes and command type of the byte ring fifo
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    localparam int DEPTH      = 1024;
    localparam int MAX_BURST  = 64;
    localparam int PUSH_BYTES = 8;

    localparam int PTR_W      = $clog2(DEPTH);
    localparam int SZ_W       = PTR_W + 1;
    localparam int LEN_W      = PTR_W;
    localparam int CNT_W      = 7;
    localparam int OP_W       = 3;
    localparam int CFG_W      = 11;
    localparam int DATA_W     = 8 * PUSH_BYTES;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_CPEEK = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        K_PUSH,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               pop;
        logic               contig;
        logic [CNT_W-1:0]   cnt;
        logic [DATA_W-1:0]  data;
    } t_cmd;

endpackage

`default_nettype wire

@@ design/brf_front.sv @@
// ----------------------------------------------------------------------------
// brf_front
// input side: takes stream beats and turns them into classified commands
// ----------------------------------------------------------------------------
`default_nettype none

module brf_front (
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [brf_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // op, count, push_bytes
    output logic                                    o_cmd_valid,
    input  wire logic                               i_cmd_ready,
    output brf_pkg::t_cmd                           o_cmd
);

    brf_pkg::t_op                   op;
    logic [brf_pkg::CNT_W-1:0]      count;
    logic [brf_pkg::DATA_W-1:0]     bytes;

    assign op    = brf_pkg::t_op'(i_s_tdata[brf_pkg::OP_W-1:0]);
    assign count = i_s_tdata[brf_pkg::OP_W +: brf_pkg::CNT_W];
    assign bytes = i_s_tdata[brf_pkg::OP_W + brf_pkg::CNT_W +: brf_pkg::DATA_W];

    assign o_s_tready  = i_cmd_ready;
    assign o_cmd_valid = i_s_tvalid;

    always_comb begin
        o_cmd.kind   = brf_pkg::K_NOP;
        o_cmd.pop    = 1'b0;
        o_cmd.contig = 1'b0;
        o_cmd.cnt    = '0;
        o_cmd.data   = bytes;
        case (op)
            brf_pkg::OP_PUSH: begin
                o_cmd.kind = brf_pkg::K_PUSH;
                // bad byte count becomes zero, rejected behind
                if ((count != '0) && (count <= brf_pkg::CNT_W'(brf_pkg::PUSH_BYTES))) begin
                    o_cmd.cnt = count;
                end
            end
            brf_pkg::OP_POP, brf_pkg::OP_PEEK, brf_pkg::OP_CPEEK: begin
                o_cmd.kind   = brf_pkg::K_READ;
                o_cmd.pop    = (op == brf_pkg::OP_POP);
                o_cmd.contig = (op == brf_pkg::OP_CPEEK);
                if (count > brf_pkg::CNT_W'(brf_pkg::MAX_BURST)) begin
                    o_cmd.cnt = brf_pkg::CNT_W'(brf_pkg::MAX_BURST);
                end else begin
                    o_cmd.cnt = count;
                end
            end
            brf_pkg::OP_CLEAR: begin
                o_cmd.kind = brf_pkg::K_CLEAR;
            end
            default: begin
                o_cmd.kind = brf_pkg::K_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/brf_cmd_q.sv @@
// ----------------------------------------------------------------------------
// brf_cmd_q
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module brf_cmd_q (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire brf_pkg::t_cmd  i_in_cmd,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output brf_pkg::t_cmd       o_out_cmd
);

    brf_pkg::t_cmd                  r_ent [brf_pkg::Q_DEPTH];
    logic [brf_pkg::Q_PTR_W-1:0]    r_wp;
    logic [brf_pkg::Q_PTR_W-1:0]    r_rp;
    logic [brf_pkg::Q_CNT_W-1:0]    r_cnt;
    logic [brf_pkg::Q_CNT_W-1:0]    n_cnt;
    logic                           push;
    logic                           pop;

    assign o_in_ready  = (r_cnt != brf_pkg::Q_CNT_W'(brf_pkg::Q_DEPTH));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_cmd   = r_ent[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + brf_pkg::Q_CNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - brf_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + brf_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + brf_pkg::Q_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/brf_back.sv @@
// ----------------------------------------------------------------------------
// brf_back
// execution side: ring store, pointers, size register and result register
// ----------------------------------------------------------------------------
`default_nettype none

module brf_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_ready,
    input  wire brf_pkg::t_cmd                  i_cmd,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [brf_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [brf_pkg::OUT_TDATA_W-1:0]     o_m_tdata,   // byte_out, accepted, stored_length, free_length
    output logic                                o_m_tlast,
    output logic                                o_m_tuser    // byte_valid
);

    localparam int SZ_W  = brf_pkg::SZ_W;
    localparam int PTR_W = brf_pkg::PTR_W;
    localparam int LEN_W = brf_pkg::LEN_W;
    localparam int CNT_W = brf_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_EMIT,
        S_RESP
    } t_state;

    t_state                         r_state,    n_state;
    logic [SZ_W-1:0]                r_sz,       n_sz;
    logic [PTR_W-1:0]               r_wr_idx,   n_wr_idx;
    logic [PTR_W-1:0]               r_rd_idx,   n_rd_idx;
    logic [PTR_W-1:0]               r_pos,      n_pos;
    logic [CNT_W-1:0]               r_left,     n_left;
    logic [CNT_W-1:0]               r_acc,      n_acc;
    logic [LEN_W-1:0]               r_res_len,  n_res_len;
    logic [LEN_W-1:0]               r_res_free, n_res_free;
    logic [brf_pkg::DATA_W-1:0]     r_data,     n_data;
    logic                           r_o_valid,  n_o_valid;
    logic [7:0]                     r_o_byte,   n_o_byte;
    logic                           r_o_bv,     n_o_bv;
    logic                           r_o_last,   n_o_last;
    logic [CNT_W-1:0]               r_o_acc,    n_o_acc;
    logic [LEN_W-1:0]               r_o_len,    n_o_len;
    logic [LEN_W-1:0]               r_o_free,   n_o_free;

    logic [7:0]                     r_mem [brf_pkg::DEPTH];
    logic [7:0]                     r_rdata;

    logic                           out_free;
    logic                           cfg_fire;
    logic [SZ_W-1:0]                diff;
    logic [SZ_W-1:0]                len;
    logic [SZ_W-1:0]                free;
    logic [SZ_W-1:0]                cnt_x;
    logic [SZ_W-1:0]                n_lim;
    logic [SZ_W-1:0]                n_rd;
    logic [SZ_W-1:0]                to_end;
    logic [SZ_W-1:0]                rd_sum;
    logic [SZ_W-1:0]                after_len;
    logic [SZ_W-1:0]                after_free;
    logic [SZ_W-1:0]                cfg_sz;
    logic                           push_fits;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [SZ_W-1:0] sz);
        logic [SZ_W-1:0] s;
        s = {1'b0, p} + SZ_W'(1);
        if (s >= sz) begin
            return '0;
        end
        return s[PTR_W-1:0];
    endfunction

    assign out_free    = !r_o_valid || i_m_tready;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_cmd_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_cmd_ready = (r_state == S_IDLE);

    // occupancy from the pointers
    assign diff  = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
    assign len   = (r_wr_idx >= r_rd_idx) ? diff : diff + r_sz;
    assign free  = r_sz - SZ_W'(1) - len;
    assign cnt_x = SZ_W'(i_cmd.cnt);

    assign push_fits = (i_cmd.cnt != '0) && (cnt_x <= free);

    // read length clipped to stored bytes and, for contiguous peek, to ring end
    assign to_end = r_sz - {1'b0, r_rd_idx};
    assign n_lim  = (cnt_x > len) ? len : cnt_x;
    assign n_rd   = (i_cmd.contig && (n_lim > to_end)) ? to_end : n_lim;
    assign rd_sum = {1'b0, r_rd_idx} + n_rd;

    always_comb begin
        case (i_cmd.kind)
            brf_pkg::K_PUSH:  after_len = push_fits ? len + cnt_x : len;
            brf_pkg::K_READ:  after_len = i_cmd.pop ? len - n_rd : len;
            brf_pkg::K_CLEAR: after_len = '0;
            default:          after_len = len;
        endcase
    end
    assign after_free = r_sz - SZ_W'(1) - after_len;

    always_comb begin
        if (i_cfg_data < brf_pkg::CFG_W'(2)) begin
            cfg_sz = SZ_W'(2);
        end else if (i_cfg_data > brf_pkg::CFG_W'(brf_pkg::DEPTH)) begin
            cfg_sz = SZ_W'(brf_pkg::DEPTH);
        end else begin
            cfg_sz = SZ_W'(i_cfg_data);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sz       = r_sz;
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_left     = r_left;
        n_acc      = r_acc;
        n_res_len  = r_res_len;
        n_res_free = r_res_free;
        n_data     = r_data;
        n_o_valid  = r_o_valid && !i_m_tready;
        n_o_byte   = r_o_byte;
        n_o_bv     = r_o_bv;
        n_o_last   = r_o_last;
        n_o_acc    = r_o_acc;
        n_o_len    = r_o_len;
        n_o_free   = r_o_free;
        n_pos      = r_rd_idx;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_res_len  = after_len[LEN_W-1:0];
                    n_res_free = after_free[LEN_W-1:0];
                    n_acc      = '0;
                    n_state    = S_RESP;
                    case (i_cmd.kind)
                        brf_pkg::K_PUSH: begin
                            if (push_fits) begin
                                n_acc   = i_cmd.cnt;
                                n_left  = i_cmd.cnt;
                                n_data  = i_cmd.data;
                                n_state = S_PUSH;
                            end
                        end
                        brf_pkg::K_READ: begin
                            if (n_rd != '0) begin
                                n_acc   = n_rd[CNT_W-1:0];
                                n_left  = n_rd[CNT_W-1:0];
                                n_state = S_EMIT;
                                if (i_cmd.pop) begin
                                    n_rd_idx = (rd_sum >= r_sz) ? PTR_W'(rd_sum - r_sz)
                                                                : rd_sum[PTR_W-1:0];
                                end
                            end
                        end
                        brf_pkg::K_CLEAR: begin
                            n_wr_idx = '0;
                            n_rd_idx = '0;
                        end
                        default: begin
                        end
                    endcase
                end else if (cfg_fire) begin
                    n_sz     = cfg_sz;
                    n_wr_idx = '0;
                    n_rd_idx = '0;
                end
            end
            S_PUSH: begin
                n_wr_idx = next_ptr(r_wr_idx, r_sz);
                n_data   = r_data >> 8;
                n_left   = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_RESP;
                end
            end
            S_EMIT: begin
                n_pos = r_pos;
                if (out_free) begin
                    n_pos     = next_ptr(r_pos, r_sz);
                    n_o_valid = 1'b1;
                    n_o_byte  = r_rdata;
                    n_o_bv    = 1'b1;
                    n_o_last  = (r_left == CNT_W'(1));
                    n_o_acc   = r_acc;
                    n_o_len   = r_res_len;
                    n_o_free  = r_res_free;
                    n_left    = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_byte  = '0;
                    n_o_bv    = 1'b0;
                    n_o_last  = 1'b1;
                    n_o_acc   = r_acc;
                    n_o_len   = r_res_len;
                    n_o_free  = r_res_free;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sz      <= SZ_W'(brf_pkg::DEPTH);
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sz      <= n_sz;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_left    <= n_left;
            r_o_valid <= n_o_valid;
        end
        r_pos      <= n_pos;
        r_acc      <= n_acc;
        r_res_len  <= n_res_len;
        r_res_free <= n_res_free;
        r_data     <= n_data;
        r_o_byte   <= n_o_byte;
        r_o_bv     <= n_o_bv;
        r_o_last   <= n_o_last;
        r_o_acc    <= n_o_acc;
        r_o_len    <= n_o_len;
        r_o_free   <= n_o_free;
    end

    // byte store, read data follows the next read position
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_mem[r_wr_idx] <= r_data[7:0];
        end
        r_rdata <= r_mem[n_pos];
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_bv;
    assign o_m_tdata  = {5'b0, r_o_free, r_o_len, r_o_acc, r_o_byte};

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("emit with no bytes left");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wr_idx} < r_sz) && ({1'b0, r_rd_idx} < r_sz))
        else $error("pointer beyond ring size");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (r_wr_idx == '0) && (r_rd_idx == '0))
        else $error("size write did not empty the ring");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_bv) |-> r_o_last)
        else $error("byteless result without last");

    a_len_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |->
            (SZ_W'(r_res_len) + SZ_W'(r_res_free) + SZ_W'(1) == r_sz))
        else $error("stored and free lengths do not add up");

endmodule

`default_nettype wire

@@ design/byte_ring_fifo.sv @@
// requests pass from the command queue to the back's state machine; each result is registered on the output
// push: one byte written per cycle, then one result
// pop and peek: one result per returned byte, one byteless result when nothing is returned, as for clear
// the front queue holds two requests, so input beats are taken while the back is busy, until the queue is full
// reset: synchronous active low; pointers zero, ring size 1024, store contents undefined
// ----------------------------------------------------------------------------
// byte_ring_fifo
// byte ring fifo with a programmable ring size, stream in and stream out
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [brf_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // op, count, push_bytes
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic [brf_pkg::OUT_TDATA_W-1:0]         o_m_tdata,   // byte_out, accepted, stored_length, free_length
    output logic                                    o_m_tlast,
    output logic                                    o_m_tuser,   // byte_valid
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [brf_pkg::CFG_W-1:0]          i_cfg_data   // ring_size
);

    logic           f_valid;
    logic           f_ready;
    brf_pkg::t_cmd  f_cmd;
    logic           q_valid;
    logic           q_ready;
    brf_pkg::t_cmd  q_cmd;

    brf_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    brf_cmd_q u_cmd_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (f_valid),
        .o_in_ready  (f_ready),
        .i_in_cmd    (f_cmd),
        .o_out_valid (q_valid),
        .i_out_ready (q_ready),
        .o_out_cmd   (q_cmd)
    );

    brf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks the byte ring fifo against a behavioural mirror of the ring: a short
// table of directed requests across two ring sizes, then random request
// streams per ring size, with random idling on both streams, one long output
// hold-off and drains before each ring size write
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam int      RAND_PHASES = 8;
    localparam int      PHASE_ITEMS = 43;
    localparam int      HOLD_OFF    = 400;
    localparam int      TAIL_CYCLES = 20;
    localparam longint  CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] bytes;
    } fifo_req_t;

    typedef struct {
        logic [7:0]       data;
        logic             vld;
        logic             last;
        logic [CNT_W-1:0] acc;
        logic [LEN_W-1:0] stored;
        logic [LEN_W-1:0] free_len;
    } fifo_res_t;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg;
        fifo_req_t        req;
        bit               typed;
        fifo_res_t        res;
    } dir_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;    // op, count, push_bytes
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;    // byte_out, accepted, stored_length, free_length
    logic                   o_m_tlast;
    logic                   o_m_tuser;    // byte_valid
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;   // ring_size

    byte_ring_fifo dut (.*);

    // mirror of the ring
    logic [7:0]       ring_mem [DEPTH];
    int               wr_ptr;
    int               rd_ptr;
    logic [CFG_W-1:0] ring_size_q;

    fifo_res_t due_results [$];
    dir_row_t  dir_rows [$];
    int        n_fail;
    longint    n_cycles;
    int        tx_gap_pct;
    int        rx_stall_pct;
    int        rx_hold_len;

    function automatic int ring_slots();
        if (ring_size_q < 2) return 2;
        if (ring_size_q > DEPTH) return DEPTH;
        return int'(ring_size_q);
    endfunction

    function automatic int fill_level();
        if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
        return ring_slots() - (rd_ptr - wr_ptr);
    endfunction

    function automatic int space_left();
        return ring_slots() - fill_level() - 1;
    endfunction

    function automatic int step_ptr(input int p);
        return (p + 1 >= ring_slots()) ? 0 : p + 1;
    endfunction

    function automatic fifo_res_t make_res(input logic [7:0] d, input logic v,
                                           input logic l, input int acc);
        fifo_res_t r;
        r.data     = d;
        r.vld      = v;
        r.last     = l;
        r.acc      = CNT_W'(acc);
        r.stored   = LEN_W'(fill_level());
        r.free_len = LEN_W'(space_left());
        return r;
    endfunction

    // updates the mirror and queues the beats the request should produce
    function automatic void apply_fifo_op(input fifo_req_t q, input bit typed,
                                          input fifo_res_t typed_res);
        fifo_res_t  outs [$];
        logic [7:0] grab [MAX_BURST];
        int         n;
        int         pos;
        int         acc;
        n = 0;
        acc = 0;
        if (q.op == OP_PUSH) begin
            if (q.cnt >= 1 && q.cnt <= PUSH_BYTES && int'(q.cnt) <= space_left()) begin
                for (int i = 0; i < int'(q.cnt); i++) begin
                    ring_mem[wr_ptr] = q.bytes[8*i +: 8];
                    wr_ptr = step_ptr(wr_ptr);
                end
                acc = q.cnt;
            end
            outs.push_back(make_res(8'd0, 1'b0, 1'b1, acc));
        end else if (q.op == OP_POP || q.op == OP_PEEK || q.op == OP_CPEEK) begin
            n = q.cnt;
            if (n > MAX_BURST) n = MAX_BURST;
            if (n > fill_level()) n = fill_level();
            if (q.op == OP_CPEEK && n > ring_slots() - rd_ptr) n = ring_slots() - rd_ptr;
            pos = rd_ptr;
            for (int i = 0; i < n; i++) begin
                grab[i] = ring_mem[pos];
                pos = step_ptr(pos);
            end
            if (q.op == OP_POP) rd_ptr = pos;
            if (n == 0) begin
                outs.push_back(make_res(8'd0, 1'b0, 1'b1, 0));
            end
            for (int i = 0; i < n; i++) begin
                outs.push_back(make_res(grab[i], 1'b1, (i + 1 == n), n));
            end
        end else begin
            if (q.op == OP_CLEAR) begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            outs.push_back(make_res(8'd0, 1'b0, 1'b1, 0));
        end
        if (typed) begin
            due_results.push_back(typed_res);
        end else begin
            foreach (outs[i]) due_results.push_back(outs[i]);
        end
    endfunction

    function automatic void add_req(input logic [OP_W-1:0] op, input int cnt,
                                    input logic [DATA_W-1:0] d, input bit typed = 0,
                                    input int acc = 0, input int st = 0, input int fr = 0);
        dir_row_t r;
        r.is_cfg         = 0;
        r.cfg            = '0;
        r.req.op         = op;
        r.req.cnt        = CNT_W'(cnt);
        r.req.bytes      = d;
        r.typed          = typed;
        r.res.data       = 8'd0;
        r.res.vld        = 1'b0;
        r.res.last       = 1'b1;
        r.res.acc        = CNT_W'(acc);
        r.res.stored     = LEN_W'(st);
        r.res.free_len   = LEN_W'(fr);
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input int v);
        dir_row_t r;
        r = dir_rows[0];
        r.is_cfg = 1;
        r.cfg    = CFG_W'(v);
        dir_rows.push_back(r);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int read_count();
        int w;
        w = $urandom_range(0, 99);
        if (w < 70) return $urandom_range(1, 16);
        if (w < 85) return $urandom_range(17, MAX_BURST);
        if (w < 93) return $urandom_range(MAX_BURST + 1, 127);
        return 0;
    endfunction

    function automatic fifo_req_t random_req();
        fifo_req_t r;
        int        w;
        w = $urandom_range(0, 99);
        r.bytes = {$urandom, $urandom};
        if (w < 45) begin
            r.op = OP_PUSH;
            if ($urandom_range(0, 99) < 8) begin
                r.cnt = ($urandom_range(0, 1) == 0) ? CNT_W'(0)
                                                    : CNT_W'($urandom_range(PUSH_BYTES + 1, 127));
            end else begin
                r.cnt = CNT_W'($urandom_range(1, PUSH_BYTES));
            end
        end else begin
            if (w < 70) r.op = OP_POP;
            else if (w < 80) r.op = OP_PEEK;
            else if (w < 92) r.op = OP_CPEEK;
            else if (w < 97) r.op = OP_CLEAR;
            else if (w < 98) r.op = OP_SPARE_LO;
            else if (w < 99) r.op = OP_SPARE_MID;
            else r.op = OP_SPARE_HI;
            r.cnt = CNT_W'(read_count());
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_req(input fifo_req_t q, input bit typed, input fifo_res_t typed_res);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? gap_len() : 0;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {6'd0, q.bytes, q.cnt, q.op};
        do @(posedge i_clk); while (!o_s_tready);
        apply_fifo_op(q, typed, typed_res);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_ring_size(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        ring_size_q = v;
        wr_ptr = 0;
        rd_ptr = 0;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output stall generator
    initial begin : rx_side
        int rx_wait;
        rx_wait = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                rx_wait = rx_hold_len;
                rx_hold_len = 0;
            end else if (rx_wait == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                rx_wait = gap_len();
            end
            if (rx_wait > 0) begin
                i_m_tready = 1'b0;
                rx_wait--;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        fifo_res_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing outstanding");
                n_fail++;
            end else begin
                want = due_results.pop_front();
                check_field("byte_out", 16'(want.data), 16'(o_m_tdata[7:0]));
                check_field("byte_valid", 16'(want.vld), 16'(o_m_tuser));
                check_field("last", 16'(want.last), 16'(o_m_tlast));
                check_field("accepted", 16'(want.acc), 16'(o_m_tdata[14:8]));
                check_field("stored_length", 16'(want.stored), 16'(o_m_tdata[24:15]));
                check_field("free_length", 16'(want.free_len), 16'(o_m_tdata[34:25]));
            end
        end
    end

    initial begin : stimulus
        fifo_req_t q;
        fifo_res_t none;
        int        v;
        n_fail       = 0;
        n_cycles     = 0;
        rx_hold_len  = 0;
        rx_stall_pct = 30;
        tx_gap_pct   = 30;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        for (int i = 0; i < DEPTH; i++) ring_mem[i] = 8'd0;
        wr_ptr      = 0;
        rd_ptr      = 0;
        ring_size_q = CFG_W'(DEPTH);
        none        = make_res(8'd0, 1'b0, 1'b1, 0);

        // empty after reset, rejected pushes, full-width data, clipping, spare ops
        add_req(OP_POP, 5, '0, 1, 0, 0, 1023);
        add_req(OP_PEEK, 0, '1, 1, 0, 0, 1023);
        add_req(OP_PUSH, 0, 64'h1122334455667788, 1, 0, 0, 1023);
        add_req(OP_PUSH, PUSH_BYTES + 1, '1, 1, 0, 0, 1023);
        add_req(OP_PUSH, 127, '1, 1, 0, 0, 1023);
        add_req(OP_PUSH, PUSH_BYTES, '1, 1, 8, 8, 1015);
        add_req(OP_PUSH, 1, '0, 1, 1, 9, 1014);
        add_req(OP_PUSH, PUSH_BYTES, 64'h0123456789abcdef, 1, 8, 17, 1006);
        add_req(OP_PEEK, 3, '0);
        add_req(OP_CPEEK, 127, '0);
        add_req(OP_POP, 0, '0, 1, 0, 17, 1006);
        add_req(OP_POP, 2, '0);
        add_req(OP_SPARE_LO, 3, '0, 1, 0, 15, 1008);
        add_req(OP_SPARE_MID, 64, '1, 1, 0, 15, 1008);
        add_req(OP_SPARE_HI, 127, '0, 1, 0, 15, 1008);
        add_req(OP_POP, 127, '0);
        add_req(OP_PUSH, PUSH_BYTES, 64'ha5a5a5a5a5a5a5a5, 1, 8, 8, 1015);
        add_req(OP_CLEAR, 0, '0, 1, 0, 0, 1023);
        add_req(OP_POP, 1, '0, 1, 0, 0, 1023);
        // smallest ring: one byte fits, wrap of both pointers
        add_cfg(2);
        add_req(OP_PUSH, 1, 64'h5a, 1, 1, 1, 0);
        add_req(OP_PUSH, 1, 64'h3c, 1, 0, 1, 0);
        add_req(OP_POP, 1, '0);
        add_req(OP_PUSH, 1, 64'hc3, 1, 1, 1, 0);
        add_req(OP_CPEEK, 5, '0);
        add_req(OP_POP, 4, '0);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_ring_size(dir_rows[i].cfg);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: v = $urandom_range(3, 12);
                1: v = 2047;
                2: v = 0;
                3: v = 1;
                4: v = DEPTH;
                5: v = $urandom_range(DEPTH + 1, 2046);
                default: v = $urandom_range(3, 40);
            endcase
            write_ring_size(CFG_W'(v));
            if (p == 0) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else if (p == 1) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 20;
                rx_hold_len  = HOLD_OFF;
            end else begin
                tx_gap_pct   = $urandom_range(10, 50);
                rx_stall_pct = $urandom_range(10, 50);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                q = random_req();
                send_req(q, 1'b0, none);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
